// ===== rtl/kpi_pkg.sv =====
// Shared constants and codes for the keyframe pose interpolator.
`timescale 1ns / 1ps
`default_nettype none
package kpi_pkg;

  // Item function codes
  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_SAMPLE = 2'd1;
  localparam logic [1:0] FN_START  = 2'd2;
  localparam logic [1:0] FN_TICK   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_CUBIC = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_TICKS = 2'd2;

  // Fixed-point constants, Q30 unless noted
  localparam longint ONE30     = 64'sd1 <<< 30;
  localparam longint SLERP_LIM = (64'sd1 <<< 28) - 64'sd32;  // Q4.28 dot limit
  localparam longint AS_A0     = 64'sd15707288 * ONE30 / 64'sd10000000;
  localparam longint AS_A1     = -(64'sd2121144 * ONE30 / 64'sd10000000);
  localparam longint AS_A2     = 64'sd742610 * ONE30 / 64'sd10000000;
  localparam longint AS_A3     = -(64'sd187293 * ONE30 / 64'sd10000000);
  localparam longint SIN_C3    = ONE30 / 64'sd6;
  localparam longint SIN_C5    = ONE30 / 64'sd120;
  localparam longint SIN_C7    = ONE30 / 64'sd5040;
  localparam longint SIN_C9    = ONE30 / 64'sd362880;

  // Divider length in iterations, one quotient bit each
  localparam int DIV_W = 48;

endpackage
`default_nettype wire

// ===== rtl/keyframe_pose_interpolator.sv =====
// Keyframe table with Catmull-Rom / linear position and slerp rotation (lerp fallback), one shared multiplier.
// A write gives no result; a sample with zero fraction returns the stored keyframe after the reads;
// an interpolated sample is dominated by the 1-bit-per-cycle divider (one divide per
// quaternion component when slerp is used) and the 31-step square root; a playback tick adds
// a time division first. A finished tick answers straight from idle. One item at a time (busy).
// Reset: synchronous, clears control and config registers; keyframe table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_pose_interpolator import kpi_pkg::*; #(
  parameter int MAX_KEYFRAMES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         func,
  input  logic [3:0]         key_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_rot_w,
  input  logic signed [15:0] in_rot_x,
  input  logic signed [15:0] in_rot_y,
  input  logic signed [15:0] in_rot_z,
  input  logic [23:0]        sample_time,
  output logic               result_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_rot_w,
  output logic signed [15:0] out_rot_x,
  output logic signed [15:0] out_rot_y,
  output logic signed [15:0] out_rot_z,
  output logic               playback_done
);

  localparam int IW = $clog2(MAX_KEYFRAMES);

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_DEND, S_POSE, S_RD, S_PINIT, S_PMUL, S_PADD, S_PFIN,
    S_DOT, S_DACC, S_DCHK, S_SQRT, S_AMUL, S_AADD, S_RMUL, S_TH, S_TBMUL, S_TB,
    S_SINIT, S_X2MUL, S_X2, S_SMUL, S_SADD, S_SXMUL, S_SFIN, S_W1, S_W2, S_W3,
    S_LMUL, S_LADD
  } state_t;

  state_t state;

  // Configuration and playback state
  logic        cubic_mode;
  logic [4:0]  keyframe_count;
  logic [15:0] total_ticks;
  logic [16:0] tick_counter;

  // Keyframe memories
  logic [95:0] pos_mem [MAX_KEYFRAMES];
  logic [63:0] rot_mem [MAX_KEYFRAMES];
  logic [95:0] rd_pos;
  logic [63:0] rd_rot;
  logic [IW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  // Datapath registers
  logic [37:0]        t_reg;
  logic [15:0]        u_r;
  logic [IW-1:0]      prev, frame, i0, i3;
  logic [2:0]         rd_k;
  logic [1:0]         step, comp, sin_k;
  logic [95:0]        p_r [4];
  logic [63:0]        qa_r, qb_r;
  logic signed [16:0] z [4];
  logic signed [33:0] d;
  logic [30:0]        c_r;
  logic [61:0]        sq_v, sq_r, sq_bit;
  logic signed [63:0] acc;
  logic signed [71:0] prod;
  logic signed [32:0] th, tb, x, wa, wb, st;
  logic signed [33:0] x2;
  logic signed [47:0] num_acc;
  logic [47:0]        div_num;
  logic [31:0]        den, rem;
  logic [5:0]         cnt;
  logic               div_tick, neg;
  logic signed [31:0] pos_o [3];
  logic signed [15:0] rot_o [4];

  // Combinational helpers
  logic [4:0]         n_eff, n_m1;
  logic [15:0]        total_eff;
  logic [16:0]        tk_sel;
  logic [47:0]        tick_num;
  logic [37:0]        tmax, t_cl;
  logic [5:0]         whole, frame6, i3n;
  logic signed [37:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [71:0] mul_p;
  logic signed [63:0] sh30, sh16r;
  logic signed [37:0] e0, e1, e2, e3, c3, c2, c1, c0;
  logic signed [63:0] pos_coef, acos_coef, sin_coef;
  logic signed [15:0] qa_j, qb_j;
  logic signed [33:0] d_abs;
  logic [61:0]        sq_try;
  logic [32:0]        rem_sh;
  logic               div_ge;
  logic [31:0]        rem_nx;
  logic signed [47:0] w_sum;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return 32'(v);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    else if (v < -64'sd32768) return 16'sh8000;
    else return 16'(v);
  endfunction

  function automatic logic signed [15:0] qsat(input logic n, input logic [47:0] q);
    if (n) return (q > 48'd32768) ? 16'sh8000 : 16'(-q);
    else return (q > 48'd32767) ? 16'sh7fff : 16'(q);
  endfunction

  // Effective count, ticks and playback time numerator
  always_comb begin
    if (keyframe_count == 5'd0) n_eff = 5'd1;
    else if (32'(keyframe_count) > MAX_KEYFRAMES) n_eff = 5'(MAX_KEYFRAMES);
    else n_eff = keyframe_count;
    n_m1      = n_eff - 5'd1;
    total_eff = (total_ticks == 16'd0) ? 16'd1 : total_ticks;
    tk_sel    = (func == FN_START) ? 17'd0 : tick_counter;
    tick_num  = (48'(n_m1) * 48'(tk_sel)) << 16;
  end

  // Time clamp and neighbor indexes
  always_comb begin
    tmax   = {17'd0, n_m1, 16'd0};
    t_cl   = (t_reg > tmax) ? tmax : t_reg;
    whole  = t_cl[21:16];
    frame6 = (whole + 6'd1 < 6'(n_eff)) ? whole + 6'd1 : 6'(n_m1);
    i3n    = (frame6 + 6'd1 < 6'(n_eff)) ? frame6 + 6'd1 : 6'(n_m1);
  end

  // Keyframe memories: write on accepted write item, registered read
  assign wr_en   = start && !busy && (func == FN_WRITE) && (32'(key_index) < MAX_KEYFRAMES);
  assign wr_addr = IW'(key_index);

  always_comb begin
    unique case (rd_k)
      3'd0:    rd_addr = i0;
      3'd1:    rd_addr = prev;
      3'd2:    rd_addr = frame;
      default: rd_addr = i3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= {in_pos_z, in_pos_y, in_pos_x};
      rot_mem[wr_addr] <= {in_rot_z, in_rot_y, in_rot_x, in_rot_w};
    end
    rd_pos <= pos_mem[rd_addr];
    rd_rot <= rot_mem[rd_addr];
  end

  // Component selects and spline coefficients
  always_comb begin
    qa_j = $signed(qa_r[16*comp +: 16]);
    qb_j = $signed(qb_r[16*comp +: 16]);
    e0 = 38'($signed(p_r[0][32*comp +: 32]));
    e1 = 38'($signed(p_r[1][32*comp +: 32]));
    e2 = 38'($signed(p_r[2][32*comp +: 32]));
    e3 = 38'($signed(p_r[3][32*comp +: 32]));
    c3 = -e0 + 38'sd3 * e1 - 38'sd3 * e2 + e3;
    c2 = 38'sd2 * e0 - 38'sd5 * e1 + 38'sd4 * e2 - e3;
    c1 = e2 - e0;
    c0 = 38'sd2 * e1;
    unique case (step)
      2'd0:    pos_coef = 64'(c2);
      2'd1:    pos_coef = 64'(c1);
      default: pos_coef = cubic_mode ? 64'(c0) : 64'(e1);
    endcase
    unique case (step)
      2'd0:    acos_coef = AS_A2;
      2'd1:    acos_coef = AS_A1;
      default: acos_coef = AS_A0;
    endcase
    unique case (step)
      2'd0:    sin_coef = SIN_C7;
      2'd1:    sin_coef = SIN_C5;
      2'd2:    sin_coef = SIN_C3;
      default: sin_coef = ONE30;
    endcase
    d_abs  = d[33] ? -d : d;
    sq_try = sq_r + sq_bit;
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (state)
      S_PMUL:  begin mul_a = $signed(acc[37:0]);       mul_b = $signed({18'd0, u_r}); end
      S_DOT:   begin mul_a = 38'(qa_j);                mul_b = 34'(qb_j); end
      S_AMUL:  begin mul_a = $signed(acc[37:0]);       mul_b = $signed({3'd0, c_r}); end
      S_RMUL:  begin mul_a = $signed({7'd0, sq_r[30:0]}); mul_b = $signed(acc[33:0]); end
      S_TBMUL: begin mul_a = 38'(th);                  mul_b = $signed({18'd0, u_r}); end
      S_X2MUL: begin mul_a = 38'(x);                   mul_b = 34'(x); end
      S_SMUL:  begin mul_a = $signed(acc[37:0]);       mul_b = x2; end
      S_SXMUL: begin mul_a = $signed(acc[37:0]);       mul_b = 34'(x); end
      S_W1:    begin mul_a = 38'(wa);                  mul_b = 34'(qa_j); end
      S_W2:    begin mul_a = 38'(wb);                  mul_b = 34'(z[comp]); end
      S_LMUL:  begin mul_a = 38'(z[comp] - 17'(qa_j)); mul_b = $signed({18'd0, u_r}); end
      default: begin mul_a = '0;                       mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Product shifts, divider step, weighted sum
  always_comb begin
    sh30   = 64'(prod >>> 30);
    sh16r  = 64'((prod + 72'sd32768) >>> 16);
    rem_sh = {rem, div_num[DIV_W-1]};
    div_ge = rem_sh >= {1'b0, den};
    rem_nx = div_ge ? 32'(rem_sh - {1'b0, den}) : 32'(rem_sh);
    w_sum  = num_acc + 48'(prod);
  end

  assign busy = (state != S_IDLE);

  // Sequencer, datapath registers and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      cubic_mode     <= 1'b1;
      keyframe_count <= 5'd1;
      total_ticks    <= 16'd100;
      tick_counter   <= '0;
    end else begin
      result_valid <= 1'b0;
      prod         <= mul_p;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_CUBIC: cubic_mode     <= cfg_data[0];
          REG_COUNT: keyframe_count <= cfg_data[4:0];
          REG_TICKS: total_ticks    <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (func)
              FN_WRITE: ;
              FN_SAMPLE: begin
                t_reg         <= 38'(sample_time);
                playback_done <= 1'b0;
                state         <= S_POSE;
              end
              default: begin
                if (func == FN_START) tick_counter <= '0;
                if (tk_sel > 17'(total_eff)) begin
                  for (int i = 0; i < 3; i++) pos_o[i] <= '0;
                  for (int i = 0; i < 4; i++) rot_o[i] <= '0;
                  playback_done <= 1'b1;
                  result_valid  <= 1'b1;
                end else begin
                  playback_done <= 1'b0;
                  tick_counter  <= 17'(tk_sel + 17'd1);
                  div_num       <= tick_num;
                  den           <= 32'(total_eff);
                  rem           <= '0;
                  cnt           <= 6'(DIV_W - 1);
                  div_tick      <= 1'b1;
                  state         <= S_DIV;
                end
              end
            endcase
          end
        end

        // Restoring divide, one quotient bit per cycle
        S_DIV: begin
          rem     <= rem_nx;
          div_num <= {div_num[DIV_W-2:0], div_ge};
          cnt     <= cnt - 6'd1;
          if (cnt == 6'd0) state <= S_DEND;
        end

        S_DEND: begin
          if (div_tick) begin
            t_reg <= div_num[37:0];
            state <= S_POSE;
          end else begin
            rot_o[comp] <= qsat(neg, div_num);
            if (comp == 2'd3) begin
              result_valid <= 1'b1;
              state        <= S_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_W1;
            end
          end
        end

        S_POSE: begin
          u_r   <= t_cl[15:0];
          prev  <= IW'(whole);
          frame <= IW'(frame6);
          i0    <= (whole != 6'd0) ? IW'(whole - 6'd1) : '0;
          i3    <= IW'(i3n);
          rd_k  <= '0;
          state <= S_RD;
        end

        // Four neighbor reads; rotation of prev and frame ride along
        S_RD: begin
          if (rd_k != 3'd0) p_r[2'(rd_k - 3'd1)] <= rd_pos;
          if (rd_k == 3'd2) qa_r <= rd_rot;
          if (rd_k == 3'd3) qb_r <= rd_rot;
          if (rd_k == 3'd4) begin
            if (u_r == 16'd0) begin
              for (int i = 0; i < 3; i++) pos_o[i] <= $signed(p_r[1][32*i +: 32]);
              for (int i = 0; i < 4; i++) rot_o[i] <= $signed(qa_r[16*i +: 16]);
              result_valid <= 1'b1;
              state        <= S_IDLE;
            end else begin
              comp  <= '0;
              state <= S_PINIT;
            end
          end else begin
            rd_k <= rd_k + 3'd1;
          end
        end

        // Position: Horner over the fraction
        S_PINIT: begin
          acc   <= cubic_mode ? 64'(c3) : 64'(e2 - e1);
          step  <= cubic_mode ? 2'd0 : 2'd2;
          state <= S_PMUL;
        end
        S_PMUL: state <= S_PADD;
        S_PADD: begin
          acc <= pos_coef + sh16r;
          if (step == 2'd2) state <= S_PFIN;
          else begin
            step  <= step + 2'd1;
            state <= S_PMUL;
          end
        end
        S_PFIN: begin
          pos_o[comp] <= sat32(cubic_mode ? ((acc + 64'sd1) >>> 1) : acc);
          if (comp == 2'd2) begin
            comp  <= '0;
            d     <= '0;
            state <= S_DOT;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_PINIT;
          end
        end

        // Quaternion dot product
        S_DOT: state <= S_DACC;
        S_DACC: begin
          d <= d + 34'(prod);
          if (comp == 2'd3) begin
            comp  <= '0;
            state <= S_DCHK;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_DOT;
          end
        end

        // Shortest path and small-angle check
        S_DCHK: begin
          for (int j = 0; j < 4; j++)
            z[j] <= d[33] ? -17'($signed(qb_r[16*j +: 16]))
                          : 17'($signed(qb_r[16*j +: 16]));
          d <= d_abs;
          if (64'(d_abs) > SLERP_LIM) begin
            comp  <= '0;
            state <= S_LMUL;
          end else begin
            c_r    <= {d_abs[28:0], 2'b00};
            sq_v   <= 62'(31'(31'h4000_0000 - {d_abs[28:0], 2'b00})) << 30;
            sq_r   <= '0;
            sq_bit <= 62'(1) << 60;
            state  <= S_SQRT;
          end
        end

        // Integer square root, two radicand bits per cycle
        S_SQRT: begin
          if (sq_v >= sq_try) begin
            sq_v <= sq_v - sq_try;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            acc   <= AS_A3;
            step  <= '0;
            state <= S_AMUL;
          end
        end

        // Arc cosine polynomial and angle
        S_AMUL: state <= S_AADD;
        S_AADD: begin
          acc <= acos_coef + sh30;
          if (step == 2'd2) state <= S_RMUL;
          else begin
            step  <= step + 2'd1;
            state <= S_AMUL;
          end
        end
        S_RMUL: state <= S_TH;
        S_TH: begin
          th    <= 33'(sh30);
          state <= S_TBMUL;
        end
        S_TBMUL: state <= S_TB;
        S_TB: begin
          tb    <= 33'(prod >>> 16);
          sin_k <= '0;
          state <= S_SINIT;
        end

        // Sine series for ta, tb, th in turn
        S_SINIT: begin
          unique case (sin_k)
            2'd0:    x <= th - tb;
            2'd1:    x <= tb;
            default: x <= th;
          endcase
          state <= S_X2MUL;
        end
        S_X2MUL: state <= S_X2;
        S_X2: begin
          x2    <= 34'(sh30);
          acc   <= SIN_C9;
          step  <= '0;
          state <= S_SMUL;
        end
        S_SMUL: state <= S_SADD;
        S_SADD: begin
          acc <= sin_coef - sh30;
          if (step == 2'd3) state <= S_SXMUL;
          else begin
            step  <= step + 2'd1;
            state <= S_SMUL;
          end
        end
        S_SXMUL: state <= S_SFIN;
        S_SFIN: begin
          unique case (sin_k)
            2'd0:    wa <= 33'(sh30);
            2'd1:    wb <= 33'(sh30);
            default: st <= 33'(sh30);
          endcase
          if (sin_k == 2'd2) begin
            comp  <= '0;
            state <= (sh30 > 64'sd0) ? S_W1 : S_LMUL;
          end else begin
            sin_k <= sin_k + 2'd1;
            state <= S_SINIT;
          end
        end

        // Weighted sum then rounded divide by sin(th)
        S_W1: state <= S_W2;
        S_W2: begin
          num_acc <= 48'(prod);
          state   <= S_W3;
        end
        S_W3: begin
          neg      <= w_sum[47];
          div_num  <= (w_sum[47] ? 48'(-w_sum) : 48'(w_sum)) + 48'(st >>> 1);
          den      <= 32'(st);
          rem      <= '0;
          cnt      <= 6'(DIV_W - 1);
          div_tick <= 1'b0;
          state    <= S_DIV;
        end

        // Componentwise lerp fallback
        S_LMUL: state <= S_LADD;
        S_LADD: begin
          rot_o[comp] <= sat16(64'(qa_j) + sh16r);
          if (comp == 2'd3) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_LMUL;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_pos_x = pos_o[0];
  assign out_pos_y = pos_o[1];
  assign out_pos_z = pos_o[2];
  assign out_rot_w = rot_o[0];
  assign out_rot_x = rot_o[1];
  assign out_rot_y = rot_o[2];
  assign out_rot_z = rot_o[3];

  // Checks
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state == S_IDLE)
    else $error("result strobe outside idle");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FN_WRITE) |=> !result_valid)
    else $error("keyframe write produced a result");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && playback_done) |-> (out_pos_x == 0 && out_rot_w == 0))
    else $error("finished playback result carries a pose");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> den != 0)
    else $error("divide by zero in shared divider");

endmodule
`default_nettype wire
